// File: rtl/core/hsg_pkg.sv
// Package for the Halton sequence generator: widths, types, register indexes
// and step counts shared by the top level and its serial arithmetic units.
// Depends on nothing.
package hsg_pkg;

    // Widths of the stored fraction and of the element counter.
    localparam int DEN_WIDTH   = 32;
    localparam int COUNT_WIDTH = 16;

    // Fixed field widths.
    localparam int BASE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int OUT_W      = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Serial multiplier: multiplier operand holds base + 1.
    localparam int MUL_W      = BASE_W + 1;
    localparam int PROD_W     = DEN_WIDTH + MUL_W;
    localparam int DIV_CNT_W  = $clog2(DEN_WIDTH);
    localparam int MUL_CNT_W  = $clog2(MUL_W);

    // Width that holds both the incremented count and the sequence length.
    localparam int CHK_W = (COUNT_WIDTH + 1 > LEN_W) ? COUNT_WIDTH + 1 : LEN_W;

    typedef logic [DEN_WIDTH-1:0]   t_den;
    typedef logic [PROD_W-1:0]      t_prod;
    typedef logic [BASE_W-1:0]      t_base;
    typedef logic [MUL_W-1:0]       t_mul;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [OUT_W-1:0]       t_out;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [CHK_W-1:0]       t_chk;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;
    typedef logic [DIV_CNT_W-1:0]   t_div_cnt;
    typedef logic [MUL_CNT_W-1:0]   t_mul_cnt;

    // Status of a serial unit: busy while stepping, done for one cycle after.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    localparam t_cfg_idx CFG_BASE = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_LEN  = t_cfg_idx'(1);

    localparam t_base    BASE_RST = t_base'(2);
    localparam t_base    BASE_MIN = t_base'(2);
    localparam t_len     LEN_RST  = t_len'(65535);
    localparam t_len     LEN_MIN  = t_len'(1);

    localparam t_div_cnt DIV_LAST = t_div_cnt'(DEN_WIDTH - 1);
    localparam t_mul_cnt MUL_LAST = t_mul_cnt'(MUL_W - 1);

endpackage

// File: rtl/core/halton_sequence_generator.sv
// Top level of the Halton sequence generator: sequencer, fraction state,
// configuration registers and output register. Depends on hsg_pkg, hsg_div, hsg_mul.
//
//   channel  direction  handshake                 payload
//   input    in         i_valid / o_stall         i_restart
//   result   out        o_valid / i_stall         o_numerator, o_denominator, o_last, o_overflow
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is worked at a time. When the element starts a new digit the result is loaded
// after one 9-step serial multiplication; otherwise after one or more bit-serial divisions
// by the base and a 9-step multiplication of the quotient by base + 1. The next item can
// be taken in the cycle after the result is loaded. Reset is synchronous and active low
// and clears the state to 0/1 with a count of zero. A new item may be taken while a
// result waits in the output register; a finished item waits for that register to empty.
module halton_sequence_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_stall,
    output hsg_pkg::t_out         o_numerator,
    output hsg_pkg::t_out         o_denominator,
    output logic                  o_last,
    output logic                  o_overflow,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  hsg_pkg::t_cfg_idx     i_cfg_index,
    input  hsg_pkg::t_cfg_data    i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIFF    = 6'b000010,
        S_DIV     = 6'b000100,
        S_OVF_MUL = 6'b001000,
        S_MUL     = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    hsg_pkg::t_den        r_num, n_num;
    hsg_pkg::t_den        r_den, n_den;
    hsg_pkg::t_count      r_cnt, n_cnt;
    hsg_pkg::t_den        r_x, n_x;
    logic                 r_ovf, n_ovf;
    hsg_pkg::t_base       r_base;
    hsg_pkg::t_len        r_len;
    logic                 r_out_valid, n_out_valid;
    hsg_pkg::t_out        r_out_num, n_out_num;
    hsg_pkg::t_out        r_out_den, n_out_den;
    logic                 r_out_last, n_out_last;
    logic                 r_out_ovf, n_out_ovf;

    hsg_pkg::t_base       w_base;
    hsg_pkg::t_len        w_len;
    hsg_pkg::t_den        w_diff;
    logic [hsg_pkg::COUNT_WIDTH:0] w_next_cnt;
    logic                 w_last;
    logic                 w_slot_free;
    logic                 w_accept;

    logic                 w_div_start;
    hsg_pkg::t_den        w_div_dividend;
    hsg_pkg::t_den        w_quotient;
    hsg_pkg::t_unit_sts   w_div_sts;
    logic                 w_mul_start;
    hsg_pkg::t_den        w_mul_mcand;
    hsg_pkg::t_mul        w_mul_mplier;
    hsg_pkg::t_prod       w_product;
    hsg_pkg::t_unit_sts   w_mul_sts;

    hsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_base),
        .o_quotient (w_quotient),
        .o_sts      (w_div_sts)
    );

    hsg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mul_mcand),
        .i_mplier  (w_mul_mplier),
        .o_product (w_product),
        .o_sts     (w_mul_sts)
    );

    // A base below two is taken as two, a zero length as one.
    assign w_base = (r_base < hsg_pkg::BASE_MIN) ? hsg_pkg::BASE_MIN : r_base;
    assign w_len  = (r_len == '0) ? hsg_pkg::LEN_MIN : r_len;

    assign w_diff      = r_den - r_num;
    assign w_next_cnt  = {1'b0, r_cnt} + 1'b1;
    assign w_last      = (hsg_pkg::t_chk'(w_next_cnt) >= hsg_pkg::t_chk'(w_len))
                         || w_next_cnt[hsg_pkg::COUNT_WIDTH];
    assign w_slot_free = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state        = r_state;
        n_num          = r_num;
        n_den          = r_den;
        n_cnt          = r_cnt;
        n_x            = r_x;
        n_ovf          = r_ovf;
        n_out_valid    = r_out_valid && i_stall;
        n_out_num      = r_out_num;
        n_out_den      = r_out_den;
        n_out_last     = r_out_last;
        n_out_ovf      = r_out_ovf;
        w_div_start    = 1'b0;
        w_div_dividend = r_den;
        w_mul_start    = 1'b0;
        w_mul_mcand    = r_den;
        w_mul_mplier   = {1'b0, w_base};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_restart) begin
                        n_num = '0;
                        n_den = hsg_pkg::t_den'(1);
                        n_cnt = '0;
                    end
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_x   = w_diff;
                n_ovf = 1'b0;
                if (w_diff == hsg_pkg::t_den'(1)) begin
                    // Next element opens a new digit: 1 / (den * base).
                    w_mul_start = 1'b1;
                    n_state     = S_OVF_MUL;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                // Keep dividing by the base while x does not exceed the quotient.
                if (w_div_sts.done) begin
                    if (r_x <= w_quotient) begin
                        w_div_dividend = w_quotient;
                        w_div_start    = 1'b1;
                    end else begin
                        w_mul_mcand  = w_quotient;
                        w_mul_mplier = {1'b0, w_base} + 1'b1;
                        w_mul_start  = 1'b1;
                        n_state      = S_MUL;
                    end
                end
            end
            S_OVF_MUL: begin
                if (w_mul_sts.done) begin
                    if (w_product[hsg_pkg::PROD_W-1:hsg_pkg::DEN_WIDTH] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_num = hsg_pkg::t_den'(1);
                        n_den = w_product[hsg_pkg::DEN_WIDTH-1:0];
                    end
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                if (w_mul_sts.done) begin
                    n_num   = w_product[hsg_pkg::DEN_WIDTH-1:0] - r_x;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_num   = hsg_pkg::t_out'(r_num);
                    n_out_den   = hsg_pkg::t_out'(r_den);
                    n_out_ovf   = r_ovf;
                    n_out_last  = 1'b0;
                    // An overflowed item leaves the state and the count alone.
                    if (!r_ovf) begin
                        if (w_last) begin
                            n_out_last = 1'b1;
                            n_num      = '0;
                            n_den      = hsg_pkg::t_den'(1);
                            n_cnt      = '0;
                        end else begin
                            n_cnt = w_next_cnt[hsg_pkg::COUNT_WIDTH-1:0];
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_den       <= hsg_pkg::t_den'(1);
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= hsg_pkg::BASE_RST;
            r_len       <= hsg_pkg::LEN_RST;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_den       <= n_den;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hsg_pkg::CFG_BASE: r_base <= i_cfg_data[hsg_pkg::BASE_W-1:0];
                    hsg_pkg::CFG_LEN:  r_len  <= i_cfg_data[hsg_pkg::LEN_W-1:0];
                    default: begin
                        r_base <= r_base;
                    end
                endcase
            end
        end
        r_x        <= n_x;
        r_out_num  <= n_out_num;
        r_out_den  <= n_out_den;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_valid       = r_out_valid;
    assign o_numerator   = r_out_num;
    assign o_denominator = r_out_den;
    assign o_last        = r_out_last;
    assign o_overflow    = r_out_ovf;

    // The denominator is a product of bases that fitted, so it can never be zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_den != '0)
        else $error("denominator register holds zero");

    // The divider and the multiplier are used strictly one after the other.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_sts.busy && w_mul_sts.busy))
        else $error("divider and multiplier busy together");

    // An element that overflowed never closes the sequence.
    a_ovf_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> !o_last)
        else $error("overflowed item marked as last");

    // A result is only loaded from the final state of an item.
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside the output state");

endmodule

// File: rtl/core/hsg_div.sv
// Bit-serial restoring divider: a DEN_WIDTH-bit dividend by an 8-bit base,
// one quotient bit per cycle. Depends on hsg_pkg.
module hsg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hsg_pkg::t_den     i_dividend,
    input  hsg_pkg::t_base    i_divisor,
    output hsg_pkg::t_den     o_quotient,
    output hsg_pkg::t_unit_sts o_sts
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    hsg_pkg::t_div_cnt          r_step, n_step;
    hsg_pkg::t_den              r_quo, n_quo;
    hsg_pkg::t_base             r_rem, n_rem;
    logic [hsg_pkg::BASE_W:0]   w_trial;
    logic [hsg_pkg::BASE_W:0]   w_diff;
    logic                       w_fit;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    assign w_trial = {r_rem, r_quo[hsg_pkg::DEN_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_fit   = w_trial >= {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo  = {r_quo[hsg_pkg::DEN_WIDTH-2:0], w_fit};
            n_rem  = w_fit ? w_diff[hsg_pkg::BASE_W-1:0] : w_trial[hsg_pkg::BASE_W-1:0];
            n_step = r_step + 1'b1;
            if (r_step == hsg_pkg::DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_quotient = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// File: rtl/core/hsg_mul.sv
// Bit-serial shift-and-add multiplier: a DEN_WIDTH-bit operand by a 9-bit
// factor, one factor bit per cycle. Depends on hsg_pkg.
module hsg_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hsg_pkg::t_den     i_mcand,
    input  hsg_pkg::t_mul     i_mplier,
    output hsg_pkg::t_prod    o_product,
    output hsg_pkg::t_unit_sts o_sts
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    hsg_pkg::t_mul_cnt  r_step, n_step;
    hsg_pkg::t_prod     r_acc, n_acc;
    hsg_pkg::t_prod     r_mcand, n_mcand;
    hsg_pkg::t_mul      r_mplier, n_mplier;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_step   = r_step;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_start) begin
            n_busy   = 1'b1;
            n_step   = '0;
            n_acc    = '0;
            n_mcand  = hsg_pkg::t_prod'(i_mcand);
            n_mplier = i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[hsg_pkg::PROD_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[hsg_pkg::MUL_W-1:1]};
            n_step   = r_step + 1'b1;
            if (r_step == hsg_pkg::MUL_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_product  = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
